FILE: rtl/irt_pkg.sv
// irt_pkg: widths, codes and state type for the interval range table.
// No dependencies; imported by interval_range_table.
package irt_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int KEY_BITS    = 32;
	localparam int VALUE_BITS  = 8;
	localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
	localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
	// build count can run past the depth by the two inserted entries plus the tail
	localparam int BLD_BITS    = $clog2(2 * TABLE_DEPTH + 3);

	localparam logic MODE_ASSIGN = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN_LO   = 6'b000010,
		ST_PUT_BEGIN = 6'b000100,
		ST_PUT_END   = 6'b001000,
		ST_SCAN_HI   = 6'b010000,
		ST_FINISH    = 6'b100000
	} state_t;

endpackage

FILE: rtl/interval_range_table.sv
// interval_range_table: sorted boundary table with interval assign and key lookup.
// Depends on irt_pkg.
//
// One transaction is handled at a time. A lookup walks the table once, one
// entry per cycle. An assign walks it twice, once for the entries below the
// interval and the value at its end, once for the entries above, with the
// begin and end insertions between. An empty interval skips the walks. The
// new table is built in a second bank and swapped in only when it fits, so a
// rejected assign leaves the table as it was. Writing the default value
// reinitialises the table at once; after reset the table is the single
// boundary at key 0 with value 0.
module interval_range_table import irt_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [VALUE_BITS-1:0] cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  mode,
	input  logic [KEY_BITS-1:0]   key_begin,
	input  logic [KEY_BITS-1:0]   key_end,
	input  logic [VALUE_BITS-1:0] new_value,
	input  logic [KEY_BITS-1:0]   query_key,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [VALUE_BITS-1:0] found_value,
	output logic [1:0]            status,
	output logic [CNT_BITS-1:0]   boundary_count
);

	state_t                state_q;
	logic                  mode_q;
	logic [KEY_BITS-1:0]   kb_q;
	logic [KEY_BITS-1:0]   ke_q;
	logic [VALUE_BITS-1:0] nv_q;
	logic [CNT_BITS-1:0]   idx_q;
	logic [BLD_BITS-1:0]   n_q;
	logic [VALUE_BITS-1:0] acc_q;
	logic [VALUE_BITS-1:0] vbef_q;
	logic                  havebef_q;
	logic                  bank_q;
	logic [CNT_BITS-1:0]   used_q;
	logic                  fresh_q;
	logic [VALUE_BITS-1:0] dflt_q;
	status_t               st_q;

	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] found_q;
	status_t               status_q;
	logic [CNT_BITS-1:0]   count_q;

	logic [KEY_BITS-1:0]   key_mem_q [2][TABLE_DEPTH];
	logic [VALUE_BITS-1:0] val_mem_q [2][TABLE_DEPTH];

	logic [KEY_BITS-1:0]   rd_key;
	logic [VALUE_BITS-1:0] rd_val;
	logic                  last_ent;
	logic                  wr_en;
	logic [KEY_BITS-1:0]   wr_key;
	logic [VALUE_BITS-1:0] wr_val;
	logic                  room;
	logic                  in_acc;
	logic                  out_free;

	assign rd_key   = fresh_q ? '0 : key_mem_q[bank_q][idx_q[IDX_BITS-1:0]];
	assign rd_val   = fresh_q ? dflt_q : val_mem_q[bank_q][idx_q[IDX_BITS-1:0]];
	assign last_ent = (idx_q == used_q - CNT_BITS'(1));
	assign room     = (n_q < BLD_BITS'(TABLE_DEPTH));
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		wr_en  = 1'b0;
		wr_key = rd_key;
		wr_val = rd_val;
		case (state_q)
			ST_SCAN_LO: begin
				wr_en = (mode_q == MODE_ASSIGN) && (rd_key < kb_q);
			end
			ST_PUT_BEGIN: begin
				wr_en  = !havebef_q || (vbef_q != nv_q);
				wr_key = kb_q;
				wr_val = nv_q;
			end
			ST_PUT_END: begin
				wr_en  = (acc_q != nv_q);
				wr_key = ke_q;
				wr_val = acc_q;
			end
			ST_SCAN_HI: begin
				wr_en = (rd_key > ke_q);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en && room) begin
			key_mem_q[!bank_q][n_q[IDX_BITS-1:0]] <= wr_key;
			val_mem_q[!bank_q][n_q[IDX_BITS-1:0]] <= wr_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mode_q      <= MODE_ASSIGN;
			kb_q        <= '0;
			ke_q        <= '0;
			nv_q        <= '0;
			idx_q       <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			vbef_q      <= '0;
			havebef_q   <= 1'b0;
			bank_q      <= 1'b0;
			used_q      <= CNT_BITS'(1);
			fresh_q     <= 1'b1;
			dflt_q      <= '0;
			st_q        <= STAT_DONE;
			out_valid_q <= 1'b0;
			found_q     <= '0;
			status_q    <= STAT_DONE;
			count_q     <= CNT_BITS'(1);
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr_en) begin
				dflt_q  <= cfg_wr_data;
				fresh_q <= 1'b1;
				used_q  <= CNT_BITS'(1);
			end
			if (wr_en) begin
				n_q <= n_q + BLD_BITS'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						mode_q    <= mode;
						kb_q      <= key_begin;
						ke_q      <= (mode == MODE_LOOKUP) ? query_key : key_end;
						nv_q      <= new_value;
						idx_q     <= '0;
						n_q       <= '0;
						havebef_q <= 1'b0;
						if (mode == MODE_ASSIGN && !(key_begin < key_end)) begin
							st_q    <= STAT_EMPTY;
							state_q <= ST_FINISH;
						end else begin
							st_q    <= STAT_DONE;
							state_q <= ST_SCAN_LO;
						end
					end
				end
				ST_SCAN_LO: begin
					if (rd_key <= ke_q) begin
						acc_q <= rd_val;
					end
					if (wr_en) begin
						vbef_q    <= rd_val;
						havebef_q <= 1'b1;
					end
					idx_q <= idx_q + CNT_BITS'(1);
					if (last_ent) begin
						state_q <= (mode_q == MODE_LOOKUP) ? ST_FINISH : ST_PUT_BEGIN;
					end
				end
				ST_PUT_BEGIN: begin
					state_q <= ST_PUT_END;
				end
				ST_PUT_END: begin
					idx_q   <= '0;
					state_q <= ST_SCAN_HI;
				end
				ST_SCAN_HI: begin
					idx_q <= idx_q + CNT_BITS'(1);
					if (last_ent) begin
						if ((n_q + BLD_BITS'(wr_en)) > BLD_BITS'(TABLE_DEPTH)) begin
							st_q <= STAT_FULL;
						end else begin
							bank_q  <= !bank_q;
							fresh_q <= 1'b0;
							used_q  <= CNT_BITS'(n_q + BLD_BITS'(wr_en));
						end
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						found_q     <= (mode_q == MODE_LOOKUP) ? acc_q : '0;
						status_q    <= st_q;
						count_q     <= used_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign found_value    = found_q;
	assign status         = status_q;
	assign boundary_count = count_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (boundary_count != '0 && boundary_count <= CNT_BITS'(TABLE_DEPTH)))
		else $error("boundary count out of range");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_DONE || status == STAT_EMPTY || status == STAT_FULL))
		else $error("bad status code");

	a_fresh_single: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q |-> (used_q == CNT_BITS'(1)))
		else $error("reinitialised table holds more than one boundary");

	a_lookup_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && mode_q == MODE_LOOKUP) |-> (st_q == STAT_DONE))
		else $error("lookup flagged");

endmodule
